### rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 16;
  localparam int KEY_IN_W      = 16;
  localparam int REQ_W         = 2;
  localparam int COUNT_W       = 7;
  localparam int STATUS_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_INS,
    DP_LOAD_DEL,
    DP_LOAD_SRCH,
    DP_INS_SHIFT,
    DP_INS_PUT,
    DP_DEL_STEP,
    DP_DEL_LAST,
    DP_SRCH_MID,
    DP_SRCH_LO,
    DP_SRCH_HI,
    DP_CLEAR
  } dp_op_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic count_zero;
    logic full;
    logic gt;
    logic eq;
    logic ptr_one;
    logic ptr_last;
    logic range_empty;
    logic del_hit;
  } dp_stat_t;

endpackage

### rtl/sorted_key_table.sv
// Top level of the sorted key table: ordered key store with insert, delete, search, clear.
//
// The table keeps up to CAPACITY keys in ascending order in a single-port-write,
// single-port-read memory. A request word (req_type, key) is taken at a rising
// edge where start is high and busy is low; exactly one result word follows,
// shown on found, count, full_res and status for one cycle while done is high.
// The receiver cannot stall: a result is gone after its one cycle. The block
// works on one request at a time. Clear, an insert into a full table and a
// delete from an empty table are answered without a walk; an insert starts
// at the top entry and shifts each larger key up one place before the new
// key is written; a delete scans from the bottom and slides later entries
// down one place; a search halves the range with a registered memory read
// and a compare per step, until the key is found or the range is empty.
// Equal keys are kept in arrival order: an insert goes after existing equals,
// and a delete removes the first equal entry. count is the number of keys
// after the request, and it is valid in the done cycle. A new request may be
// started in the same cycle that done is high.
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_IN_W-1:0] key,
  output logic                busy,
  output logic                done,
  output logic                found,
  output logic [COUNT_W-1:0]  count,
  output logic                full_res,
  output logic [STATUS_W-1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_op_t           op;
  dp_stat_t         stat;
  status_t          status_r;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .op       (op),
    .busy     (busy),
    .done     (done),
    .found    (found),
    .status   (status_r)
  );

  skt_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .key  (key),
    .stat (stat),
    .cnt  (cnt)
  );

  // The count field is seven bits wide; larger tables report it modulo 128.
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt};
  assign count    = cnt_ext[COUNT_W-1:0];
  assign full_res = stat.full;
  assign status   = status_r;

  // A rejected insert can only happen when the table is full.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (full_res && !found))
    else $error("insert rejected while table not full");

  // A failed delete never reports the key as found.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOT_FOUND) |-> !found)
    else $error("delete miss reported found");

  // After acceptance the block either answers at once or reports busy.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request accepted but neither answered nor busy");

endmodule

### rtl/skt_dp.sv
// Datapath of the sorted key table: key memory, pointers, count and compares.
module skt_dp import skt_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  logic [KEY_IN_W-1:0] key,
  output dp_stat_t            stat,
  output logic [CNT_W-1:0]    cnt
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 wr_en;

  logic [KEY_WIDTH-1:0] key_r, key_r_next;
  logic [CNT_W-1:0]     cnt_next;
  logic [CNT_W-1:0]     ptr, ptr_next;
  logic [CNT_W-1:0]     lo, lo_next;
  logic [CNT_W-1:0]     hi, hi_next;
  logic [CNT_W-1:0]     mid, mid_next;
  logic                 hit, hit_next;

  logic [KEY_WIDTH+KEY_IN_W-1:0] key_ext;
  logic [CNT_W-1:0]     ptr_m1, ptr_m2, ptr_p1, cnt_m1, mid_calc;

  assign key_ext  = {{KEY_WIDTH{1'b0}}, key};
  assign ptr_m1   = ptr - CNT_W'(1);
  assign ptr_m2   = ptr - CNT_W'(2);
  assign ptr_p1   = ptr + CNT_W'(1);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign mid_calc = lo + ((hi - lo) >> 1);

  assign stat.count_zero  = (cnt == '0);
  assign stat.full        = (cnt == CNT_W'(CAPACITY));
  assign stat.gt          = (rd_data > key_r);
  assign stat.eq          = (rd_data == key_r);
  assign stat.ptr_one     = (ptr == CNT_W'(1));
  assign stat.ptr_last    = (ptr_p1 == cnt);
  assign stat.range_empty = (lo >= hi);
  assign stat.del_hit     = hit | (rd_data == key_r);

  always_comb begin
    key_r_next = key_r;
    cnt_next   = cnt;
    ptr_next   = ptr;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    hit_next   = hit;
    rd_addr    = '0;
    wr_addr    = ptr[ADDR_W-1:0];
    wr_data    = rd_data;
    wr_en      = 1'b0;
    case (op)
      DP_LOAD_INS: begin
        key_r_next = key_ext[KEY_WIDTH-1:0];
        ptr_next   = cnt;
        rd_addr    = cnt_m1[ADDR_W-1:0];
      end
      DP_LOAD_DEL: begin
        key_r_next = key_ext[KEY_WIDTH-1:0];
        ptr_next   = '0;
        hit_next   = 1'b0;
        rd_addr    = '0;
      end
      DP_LOAD_SRCH: begin
        key_r_next = key_ext[KEY_WIDTH-1:0];
        lo_next    = '0;
        hi_next    = cnt;
      end
      DP_INS_SHIFT: begin
        // Move the larger entry up one place and fetch the one below it.
        wr_en    = 1'b1;
        wr_addr  = ptr[ADDR_W-1:0];
        wr_data  = rd_data;
        ptr_next = ptr_m1;
        rd_addr  = ptr_m2[ADDR_W-1:0];
      end
      DP_INS_PUT: begin
        wr_en    = 1'b1;
        wr_addr  = ptr[ADDR_W-1:0];
        wr_data  = key_r;
        cnt_next = cnt + CNT_W'(1);
      end
      DP_DEL_STEP: begin
        // Once the victim is found, every later entry slides down one place.
        wr_en    = hit;
        wr_addr  = ptr_m1[ADDR_W-1:0];
        hit_next = stat.del_hit;
        ptr_next = ptr_p1;
        rd_addr  = ptr_p1[ADDR_W-1:0];
      end
      DP_DEL_LAST: begin
        wr_en    = hit;
        wr_addr  = ptr_m1[ADDR_W-1:0];
        if (stat.del_hit) begin
          cnt_next = cnt_m1;
        end
      end
      DP_SRCH_MID: begin
        mid_next = mid_calc;
        rd_addr  = mid_calc[ADDR_W-1:0];
      end
      DP_SRCH_LO: begin
        lo_next = mid + CNT_W'(1);
      end
      DP_SRCH_HI: begin
        hi_next = mid;
      end
      DP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    key_r <= key_r_next;
    ptr   <= ptr_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    hit   <= hit_next;
  end

endmodule

### rtl/skt_ctrl.sv
// Controller of the sorted key table: request sequencing and result strobe.
module skt_ctrl import skt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_stat_t         stat,
  output dp_op_t           op,
  output logic             busy,
  output logic             done,
  output logic             found,
  output status_t          status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_DEL_WALK,
    S_SRCH_RD,
    S_SRCH_CMP
  } state_t;

  state_t  state, state_next;
  logic    done_next, found_next;
  status_t status_next;

  always_comb begin
    state_next  = state;
    op          = DP_NOP;
    done_next   = 1'b0;
    found_next  = 1'b0;
    status_next = ST_DONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_INSERT: begin
              if (stat.full) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else begin
                op         = DP_LOAD_INS;
                state_next = stat.count_zero ? S_INS_PUT : S_INS_WALK;
              end
            end
            REQ_DELETE: begin
              if (stat.count_zero) begin
                done_next   = 1'b1;
                status_next = ST_NOT_FOUND;
              end else begin
                op         = DP_LOAD_DEL;
                state_next = S_DEL_WALK;
              end
            end
            REQ_SEARCH: begin
              op         = DP_LOAD_SRCH;
              state_next = S_SRCH_RD;
            end
            REQ_CLEAR: begin
              op        = DP_CLEAR;
              done_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_WALK: begin
        if (stat.gt) begin
          op = DP_INS_SHIFT;
          if (stat.ptr_one) begin
            state_next = S_INS_PUT;
          end
        end else begin
          op         = DP_INS_PUT;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INS_PUT: begin
        op         = DP_INS_PUT;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_DEL_WALK: begin
        if (stat.ptr_last) begin
          op          = DP_DEL_LAST;
          done_next   = 1'b1;
          found_next  = stat.del_hit;
          status_next = stat.del_hit ? ST_DONE : ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          op = DP_DEL_STEP;
        end
      end
      S_SRCH_RD: begin
        if (stat.range_empty) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          op         = DP_SRCH_MID;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat.eq) begin
          done_next  = 1'b1;
          found_next = 1'b1;
          state_next = S_IDLE;
        end else if (stat.gt) begin
          op         = DP_SRCH_HI;
          state_next = S_SRCH_RD;
        end else begin
          op         = DP_SRCH_LO;
          state_next = S_SRCH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= done_next;
    end
    found  <= found_next;
    status <= status_next;
  end

endmodule
